>>> rtl/core/drf_pkg.sv
package drf_pkg;

    typedef struct packed {
        logic [7:0]  id_byte;
        logic        last_byte;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic       is_duplicate;
        logic [6:0] bucket_index;
    } t_rsp;

    localparam int unsigned PADDR_W             = 3;
    localparam int unsigned REG_REPEAT_INTERVAL = 0;
    localparam logic [31:0] REPEAT_INTERVAL_RST = 32'd1;

    localparam int unsigned RSP_FIFO_DEPTH = 3;
    localparam int unsigned RSP_PTR_W      = 2;

endpackage

>>> rtl/core/drf_ram.sv
module drf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/duplicate_request_filter_core.sv
// Channel   Direction  Handshake                     Payload
// req       in         i_req_valid / o_req_ready     i_req_data  (drf_pkg::t_req)
// rsp       out        o_rsp_valid / i_rsp_ready     o_rsp_data  (drf_pkg::t_rsp)
// cfg       in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One byte transfer per cycle while o_req_ready is high; the bucket read is issued
// in the accept cycle and the last-seen memory is read, compared and written back in
// the cycle after. A result passes the s1 stage registers and is then written into
// the output queue. After reset a clearing pass writes zero to every bucket, with
// o_req_ready low; configuration writes are taken throughout. Apart from that pass,
// o_req_ready drops only when the three-entry output queue and the stage in flight
// would overflow, i.e. under output stall.
module duplicate_request_filter_core #(
    parameter int unsigned N_BUCKETS = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  drf_pkg::t_req                    i_req_data,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output drf_pkg::t_rsp                    o_rsp_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drf_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import drf_pkg::*;

    localparam int unsigned AW = $clog2(N_BUCKETS);

    logic [31:0]   r_interval;
    logic          w_cfg_sel;

    logic [AW-1:0] r_rem;
    logic [AW-1:0] n_rem;
    logic [AW-1:0] w_byte_mod_tab [256];
    logic [AW-1:0] w_byte_mod;
    logic [AW:0]   w_sum;
    logic [AW-1:0] w_bucket;
    logic          w_accept;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_vld;
    logic [AW-1:0] r_s1_bkt;
    logic [31:0]   r_s1_now;
    logic [31:0]   w_rdata;
    logic [31:0]   w_stored;
    logic [31:0]   w_gap;
    logic [AW+6:0] w_bkt_ext;
    t_rsp          w_rsp;

    logic          r_wr_vld;
    logic [AW-1:0] r_wr_bkt;
    logic [31:0]   r_wr_now;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;

    t_rsp                  r_fifo [RSP_FIFO_DEPTH];
    logic [RSP_PTR_W-1:0]  r_wr_ptr;
    logic [RSP_PTR_W-1:0]  r_rd_ptr;
    logic [RSP_PTR_W-1:0]  r_cnt;
    logic                  w_pop;
    logic [RSP_PTR_W:0]    w_pending;

    // configuration
    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_REPEAT_INTERVAL));
    assign prdata    = w_cfg_sel ? r_interval : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= REPEAT_INTERVAL_RST;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_interval <= pwdata;
        end
    end

    // running remainder
    for (genvar g = 0; g < 256; g++) begin : g_mod_tab
        assign w_byte_mod_tab[g] = AW'(g % N_BUCKETS);
    end

    assign w_byte_mod = w_byte_mod_tab[i_req_data.id_byte];
    assign w_sum      = {1'b0, r_rem} + {1'b0, w_byte_mod};

    always_comb begin
        if (w_sum >= (AW+1)'(N_BUCKETS)) begin
            w_bucket = AW'(w_sum - (AW+1)'(N_BUCKETS));
        end else begin
            w_bucket = w_sum[AW-1:0];
        end
    end

    assign w_pending   = {1'b0, r_cnt} + {{RSP_PTR_W{1'b0}}, r_s1_vld};
    assign o_req_ready = !r_clr_busy && (w_pending < (RSP_PTR_W+1)'(RSP_FIFO_DEPTH));
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_rem = r_rem;
        if (w_accept) begin
            n_rem = i_req_data.last_byte ? '0 : w_bucket;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_wr_vld   <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_cnt      <= '0;
        end else begin
            r_rem    <= n_rem;
            r_s1_vld <= w_accept && i_req_data.last_byte;
            r_wr_vld <= r_s1_vld;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(N_BUCKETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (r_s1_vld) begin
                r_wr_ptr <= (r_wr_ptr == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + RSP_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + RSP_PTR_W'(1);
            end
            r_cnt <= r_cnt + RSP_PTR_W'(r_s1_vld) - RSP_PTR_W'(w_pop);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_bkt <= w_bucket;
        r_s1_now <= i_req_data.now_time;
        r_wr_bkt <= r_s1_bkt;
        r_wr_now <= r_s1_now;
        if (r_s1_vld) begin
            r_fifo[r_wr_ptr] <= w_rsp;
        end
    end

    // last-seen memory
    assign ram_we    = r_clr_busy || r_s1_vld;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_bkt;
    assign ram_wdata = r_clr_busy ? 32'd0 : r_s1_now;

    drf_ram #(
        .WIDTH (32),
        .DEPTH (N_BUCKETS)
    ) u_last_seen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (w_bucket),
        .o_rdata (w_rdata)
    );

    // forward the write of the previous cycle to a lookup of the same bucket
    assign w_stored  = (r_wr_vld && (r_wr_bkt == r_s1_bkt)) ? r_wr_now : w_rdata;
    assign w_gap     = r_s1_now - w_stored;
    assign w_bkt_ext = (AW+7)'(r_s1_bkt);

    always_comb begin
        w_rsp.is_duplicate = (w_stored != 32'd0) && (w_gap < r_interval);
        w_rsp.bucket_index = w_bkt_ext[6:0];
    end

    // output queue
    assign o_rsp_valid = (r_cnt != '0);
    assign o_rsp_data  = r_fifo[r_rd_ptr];
    assign w_pop       = o_rsp_valid && i_rsp_ready;

endmodule
